### hw/rtl/cse_pkg.sv
// cse_pkg: shared types and constants for the counting sort engine
// used by counting_sort_engine; no dependencies
`default_nettype none

package cse_pkg;

  localparam int VAL_W          = 12;
  localparam int VALUE_BITS_DEF = 12;
  localparam int MAX_ITEMS_DEF  = 1024;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic             command;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             last;
    logic             empty_res;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/cse_hist_ram.sv
// cse_hist_ram: histogram store, one write port and one registered read port
// generic over address and data width; no package dependencies
`default_nettype none

module cse_hist_ram #(
  parameter int AW = 12,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/counting_sort_engine.sv
// counting_sort_engine: histogram counting sort with ascending drain
// a load reads the bin, then writes the count plus one;
// a read walks empty bins, one per cycle, then takes one from a held bin,
// through the single histogram read port and the shared count adder
// throughput: one beat at a time, next beat taken once the block is idle
// reset: rst clears control, then a clear pass writes zero to all 2**VALUE_BITS
// bins (4096 by default) while no beat is taken
`default_nettype none

module counting_sort_engine #(
  parameter int VALUE_BITS = cse_pkg::VALUE_BITS_DEF,
  parameter int MAX_ITEMS  = cse_pkg::MAX_ITEMS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire cse_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output cse_pkg::rsp_t      rsp
);
  import cse_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMPTY = 3'd4;

  logic [2:0]    state;
  logic [VB-1:0] scan_pos;
  logic [VB-1:0] low_seen;
  logic [VB-1:0] ld_addr;
  logic [CW-1:0] items_held;
  logic          draining;

  logic          req_acc;
  logic          out_free;
  logic          rsp_load;
  logic [VB-1:0] req_addr;
  logic          ld_ok;

  logic          mem_we;
  logic [VB-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic          mem_re;
  logic [VB-1:0] mem_raddr;
  logic [CW-1:0] mem_rdata;

  logic          cnt_dec;
  logic [CW-1:0] cnt_adj;
  logic          bin_hit;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_addr  = VB'(req.value);
  assign ld_ok     = !draining && (items_held < CW'(MAX_ITEMS));
  assign bin_hit   = (mem_rdata != '0);
  assign rsp_load  = out_free && ((state == S_SCAN && bin_hit) || state == S_EMPTY);

  // shared count unit: plus one on load, minus one on drain
  assign cnt_dec = (state == S_SCAN);
  assign cnt_adj = mem_rdata + (cnt_dec ? {CW{1'b1}} : CW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_pos;
    mem_wdata = cnt_adj;
    mem_re    = 1'b0;
    mem_raddr = scan_pos;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (req_acc && req.command == CMD_LOAD && ld_ok) begin
          mem_re    = 1'b1;
          mem_raddr = req_addr;
        end else if (req_acc && req.command == CMD_READ && items_held != '0) begin
          mem_re    = 1'b1;
          mem_raddr = draining ? scan_pos : low_seen;
        end
      end
      S_LOAD: begin
        mem_we    = 1'b1;
        mem_waddr = ld_addr;
      end
      S_SCAN: begin
        if (!bin_hit) begin
          mem_re    = 1'b1;
          mem_raddr = scan_pos + VB'(1);
        end else if (out_free) begin
          mem_we = 1'b1;
        end
      end
      S_EMPTY: begin
      end
      default: begin
      end
    endcase
  end

  cse_hist_ram #(
    .AW(VB),
    .DW(CW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      scan_pos   <= '0;
      low_seen   <= '1;
      items_held <= '0;
      draining   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          scan_pos <= scan_pos + VB'(1);
          if (scan_pos == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_acc) begin
            if (req.command == CMD_LOAD) begin
              if (ld_ok) begin
                ld_addr <= req_addr;
                state   <= S_LOAD;
              end
            end else if (items_held == '0) begin
              state <= S_EMPTY;
            end else begin
              // first read of a set starts the walk at the smallest value
              if (!draining) begin
                scan_pos <= low_seen;
                draining <= 1'b1;
              end
              state <= S_SCAN;
            end
          end
        end
        S_LOAD: begin
          items_held <= items_held + CW'(1);
          if (ld_addr < low_seen) begin
            low_seen <= ld_addr;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (!bin_hit) begin
            scan_pos <= scan_pos + VB'(1);
          end else if (out_free) begin
            rsp.sorted_value <= VAL_W'(scan_pos);
            rsp.last         <= (items_held == CW'(1));
            rsp.empty_res    <= 1'b0;
            items_held       <= items_held - CW'(1);
            if (items_held == CW'(1)) begin
              draining <= 1'b0;
              low_seen <= '1;
            end
            state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            rsp.sorted_value <= '0;
            rsp.last         <= 1'b0;
            rsp.empty_res    <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.empty_res |-> rsp.sorted_value == '0 && !rsp.last)
    else $error("empty beat carries a value or last");

  a_drain_holds: assert property (@(posedge clk) disable iff (rst)
    draining |-> items_held != '0)
    else $error("draining with nothing held");

  a_last_ends_set: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && bin_hit && out_free && items_held == CW'(1)
    |=> !draining && low_seen == '1)
    else $error("final beat did not end the set");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> req_stall && !rsp_valid)
    else $error("beat moved during clear pass");
`endif

endmodule

`default_nettype wire
